@@ hw/rtl/hebp_pkg.sv @@
package hebp_pkg;

	localparam int MAX_CODE_LEN = 32;
	localparam int SYMBOL_COUNT = 256;
	localparam int TABLE_DEPTH  = 256;
	localparam int STORE_WIDTH  = 32;
	localparam int BYTE_BITS    = 8;
	localparam int ADDR_W       = $clog2(TABLE_DEPTH);
	localparam int CODE_LIM     = (MAX_CODE_LEN < STORE_WIDTH) ? MAX_CODE_LEN : STORE_WIDTH;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_END    = 2'd2
	} cmd_t;

	// table read result
	typedef struct packed {
		logic [5:0]  len;
		logic [31:0] code;
	} entry_t;

	// bytes handed from the packer to the output stage, lowest byte first
	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  cnt;
	} grp_t;

endpackage

@@ hw/rtl/hebp_table.sv @@
module hebp_table import hebp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [31:0]       wcode,
	input  logic [5:0]        wlen,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output entry_t            rd
);

	logic [31:0]            code_mem [TABLE_DEPTH];
	logic [5:0]             len_mem  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;
	logic [31:0]            code_rd_q;
	logic [5:0]             len_rd_q;
	logic                   vld_rd_q;
	logic [5:0]             wlen_c;
	logic [31:0]            wmask;

	// saturate the length, then clear code bits at or above it
	always_comb begin
		wlen_c = (wlen > 6'(CODE_LIM)) ? 6'(CODE_LIM) : wlen;
		wmask  = (wlen_c >= 6'(STORE_WIDTH)) ? '1 : ((32'd1 << wlen_c) - 32'd1);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			code_mem[waddr] <= wcode & wmask;
			len_mem[waddr]  <= wlen_c;
		end
		if (re) begin
			code_rd_q <= code_mem[raddr];
			len_rd_q  <= len_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				vld_rd_q <= vld_q[raddr];
			end
		end
	end

	// an entry never loaded reads as length zero
	assign rd.len  = vld_rd_q ? len_rd_q : 6'd0;
	assign rd.code = code_rd_q;

endmodule

@@ hw/rtl/hebp_pack.sv @@
module hebp_pack import hebp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   acc_en,
	input  cmd_t   acc_cmd,
	input  logic   acc_hit,
	input  entry_t ent,
	input  logic   emit_free,
	output logic   ready,
	output logic   grp_valid,
	output grp_t   grp
);

	logic        vld_s1;
	cmd_t        cmd_s1;
	logic        hit_s1;
	logic [7:0]  pend_bits_q;
	logic [2:0]  pend_cnt_q;
	logic [5:0]  len_eff;
	logic [5:0]  total;
	logic [39:0] acc;
	logic [39:0] rem;
	logic [2:0]  nb;
	logic [2:0]  new_cnt;
	logic [7:0]  new_bits;
	logic [7:0]  pad;
	logic        adv;

	always_comb begin
		len_eff  = hit_s1 ? ent.len : 6'd0;
		total    = {3'd0, pend_cnt_q} + len_eff;
		acc      = {32'd0, pend_bits_q} | ({8'd0, ent.code} << pend_cnt_q);
		nb       = total[5:3];
		rem      = acc >> {nb, 3'd0};
		new_cnt  = total[2:0];
		new_bits = rem[7:0] & ((8'd1 << new_cnt) - 8'd1);
		pad      = 8'(BYTE_BITS) - {5'd0, pend_cnt_q};
		grp      = '0;
		unique case (cmd_s1)
			CMD_ENCODE: begin
				grp.bytes = acc[31:0];
				grp.cnt   = nb;
			end
			CMD_END: begin
				grp.bytes = {16'd0, pad, pend_bits_q};
				grp.cnt   = (pend_cnt_q != 3'd0) ? 3'd2 : 3'd1;
			end
			default: begin
				grp = '0;
			end
		endcase
		grp_valid = vld_s1 && (grp.cnt != 3'd0);
		adv       = vld_s1 && ((grp.cnt == 3'd0) || emit_free);
		ready     = !vld_s1 || adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			cmd_s1      <= CMD_LOAD;
			hit_s1      <= 1'b0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else begin
			if (acc_en) begin
				vld_s1 <= 1'b1;
				cmd_s1 <= acc_cmd;
				hit_s1 <= acc_hit;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				unique case (cmd_s1)
					CMD_ENCODE: begin
						pend_bits_q <= new_bits;
						pend_cnt_q  <= new_cnt;
					end
					CMD_END: begin
						pend_bits_q <= '0;
						pend_cnt_q  <= '0;
					end
					default: begin
						pend_cnt_q <= pend_cnt_q;
					end
				endcase
			end
		end
	end

endmodule

@@ hw/rtl/hebp_emit.sv @@
module hebp_emit import hebp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       grp_valid,
	input  grp_t       grp,
	output logic       free,
	output logic       tvalid,
	input  logic       tready,
	output logic [7:0] tdata,
	output logic       tlast
);

	logic [31:0] buf_q;
	logic [2:0]  cnt_q;

	assign tvalid = (cnt_q != 3'd0);
	assign tdata  = buf_q[7:0];
	assign tlast  = (cnt_q == 3'd1);
	// take a new group once the last byte leaves
	assign free   = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= '0;
		end else if (grp_valid && free) begin
			buf_q <= grp.bytes;
			cnt_q <= grp.cnt;
		end else if (tvalid && tready) begin
			buf_q <= buf_q >> BYTE_BITS;
			cnt_q <= cnt_q - 3'd1;
		end
	end

endmodule

@@ hw/rtl/huffman_encode_bit_packer_unit.sv @@
// Path: an accepted item is registered in the table-read stage, its bytes then load into
// the output buffer when it is free, and the first byte is offered from there.
// Throughput: one item per cycle while items yield at most one byte and m_tready
// holds; otherwise the single-byte output stage sets the pace (up to four bytes per
// symbol, two for end of stream).
// Reset: pending bits clear and every table length reads as zero; no clearing pass.
module huffman_encode_bit_packer_unit import hebp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // symbol[7:0], code_bits[39:8], code_length[45:40]
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_byte[7:0]
	output logic        m_tlast
);

	logic              acc_en;
	cmd_t              cmd;
	logic [7:0]        symbol;
	logic              hit;
	entry_t            ent;
	logic              emit_free;
	logic              grp_valid;
	grp_t              grp;

	assign cmd    = cmd_t'(s_tuser);
	assign symbol = s_tdata[7:0];
	assign hit    = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
	assign acc_en = s_tvalid && s_tready;

	hebp_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (acc_en && (cmd == CMD_LOAD) && hit),
		.waddr  (symbol[ADDR_W-1:0]),
		.wcode  (s_tdata[39:8]),
		.wlen   (s_tdata[45:40]),
		.re     (acc_en && (cmd == CMD_ENCODE)),
		.raddr  (symbol[ADDR_W-1:0]),
		.rd     (ent)
	);

	hebp_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_en    (acc_en),
		.acc_cmd   (cmd),
		.acc_hit   (hit),
		.ent       (ent),
		.emit_free (emit_free),
		.ready     (s_tready),
		.grp_valid (grp_valid),
		.grp       (grp)
	);

	hebp_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp       (grp),
		.free      (emit_free),
		.tvalid    (m_tvalid),
		.tready    (m_tready),
		.tdata     (m_tdata),
		.tlast     (m_tlast)
	);

endmodule

@@ bench/huffman_encode_bit_packer_unit_tb.sv @@
`timescale 1ns / 1ps

module huffman_encode_bit_packer_unit_tb;
	import hebp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 440;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} out_beat_t;

	typedef struct {
		logic [1:0]      cmd;
		logic [7:0]      sym;
		logic [31:0]     code;
		logic [5:0]      len;
		bit              typed;
		int              n_typed;
		out_beat_t [3:0] typed_res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	// encoder state as seen by the bench
	logic [31:0] tbl_code [256];
	logic [5:0]  tbl_len [256];
	logic [7:0]  pend_bits;
	logic [2:0]  pend_cnt;

	out_beat_t   packed_bytes_q[$];
	logic [7:0]  live_syms[$];
	row_t        dir_rows[$];

	bit calm;
	int errors;
	int idle_cycles;
	int n_loads, n_encodes, n_ends, n_ignored, n_bytes;

	huffman_encode_bit_packer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// work out the bytes one item yields and advance the bench state
	task automatic encode_item(input logic [1:0] cmd, input logic [7:0] sym,
			input logic [31:0] code, input logic [5:0] len_in,
			output out_beat_t [3:0] res, output int n);
		logic [5:0]  len;
		logic [63:0] mask;
		logic [39:0] acc;
		int          total;
		n = 0;
		res = '0;
		unique case (cmd)
			CMD_LOAD: begin
				if (int'(sym) < SYMBOL_COUNT) begin
					len = (int'(len_in) > CODE_LIM) ? 6'(CODE_LIM) : len_in;
					mask = (64'd1 << len) - 64'd1;
					tbl_code[sym] = code & mask[31:0];
					tbl_len[sym] = len;
				end
			end
			CMD_ENCODE: begin
				if (int'(sym) < SYMBOL_COUNT && tbl_len[sym] != 6'd0) begin
					acc = ({8'd0, tbl_code[sym]} << pend_cnt) | {32'd0, pend_bits};
					total = int'(pend_cnt) + int'(tbl_len[sym]);
					while (total >= BYTE_BITS && n < 4) begin
						res[n] = '{last: (total - BYTE_BITS < BYTE_BITS), data: acc[7:0]};
						n++;
						acc = acc >> BYTE_BITS;
						total -= BYTE_BITS;
					end
					pend_cnt = 3'(total);
					pend_bits = acc[7:0] & ((8'd1 << pend_cnt) - 8'd1);
				end
			end
			CMD_END: begin
				if (pend_cnt != 3'd0) begin
					res[0] = '{last: 1'b0, data: pend_bits};
					res[1] = '{last: 1'b1, data: 8'(BYTE_BITS - int'(pend_cnt))};
					n = 2;
				end else begin
					res[0] = '{last: 1'b1, data: 8'd0};
					n = 1;
				end
				pend_bits = '0;
				pend_cnt = '0;
			end
			default: ;
		endcase
	endtask

	task automatic send_beat(input logic [1:0] cmd, input logic [7:0] sym,
			input logic [31:0] code, input logic [5:0] len);
		while (!calm && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {2'b00, len, code, sym};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic issue(input row_t r);
		out_beat_t [3:0] res;
		int              n;
		send_beat(r.cmd, r.sym, r.code, r.len);
		encode_item(r.cmd, r.sym, r.code, r.len, res, n);
		unique case (r.cmd)
			CMD_LOAD: n_loads++;
			CMD_ENCODE: n_encodes++;
			CMD_END: n_ends++;
			default: n_ignored++;
		endcase
		if (r.typed) begin
			res = r.typed_res;
			n = r.n_typed;
		end
		for (int k = 0; k < n; k++)
			packed_bytes_q.insert(packed_bytes_q.size(), res[k]);
	endtask

	function automatic row_t mk_row(input logic [1:0] cmd, input logic [7:0] sym,
			input logic [31:0] code, input logic [5:0] len, input bit typed = 1'b0,
			input int n_typed = 0, input out_beat_t [3:0] typed_res = '0);
		row_t r;
		r.cmd = cmd;
		r.sym = sym;
		r.code = code;
		r.len = len;
		r.typed = typed;
		r.n_typed = n_typed;
		r.typed_res = typed_res;
		return r;
	endfunction

	// receiver side
	always @(negedge clk) begin
		if (arst_n)
			m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
	end

	// check output beats and watch for a hang
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (m_tvalid && m_tready) begin
				n_bytes++;
				if (packed_bytes_q.size() == 0) begin
					$display("%0t: unexpected beat out_byte %02h last %b", $time, m_tdata,
						m_tlast);
					errors++;
				end else begin
					want = packed_bytes_q.pop_front();
					if (m_tdata !== want.data) begin
						$display("%0t: out_byte expected %02h actual %02h", $time,
							want.data, m_tdata);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last_of_run expected %b actual %b", $time,
							want.last, m_tlast);
						errors++;
					end
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d bytes outstanding", $time,
					idle_cycles, packed_bytes_q.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		row_t       r;
		int         sent;
		int         pick;
		logic [1:0] cmd;
		logic [7:0] sym;
		logic [5:0] len;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		calm = 1'b0;
		errors = 0;
		idle_cycles = 0;
		n_loads = 0;
		n_encodes = 0;
		n_ends = 0;
		n_ignored = 0;
		n_bytes = 0;
		pend_bits = '0;
		pend_cnt = '0;
		for (int i = 0; i < 256; i++) begin
			tbl_code[i] = '0;
			tbl_len[i] = '0;
		end

		// end right after reset, unloaded symbol, full-width codes, overlong length
		dir_rows.insert(dir_rows.size(),
			mk_row(CMD_END, 8'h00, 32'h0, 6'd0, 1, 1, {27'd0, 9'h100}));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_ENCODE, 8'h5A, 32'h0, 6'd0, 1, 0));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32, 1, 0));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_ENCODE, 8'h00, 32'h0, 6'd0, 1, 4,
			{9'h1FF, 9'h0FF, 9'h0FF, 9'h0FF}));
		dir_rows.insert(dir_rows.size(),
			mk_row(CMD_END, 8'h00, 32'h0, 6'd0, 1, 1, {27'd0, 9'h100}));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1, 0));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_ENCODE, 8'hFF, 32'h0, 6'd0, 1, 4,
			{9'h1FF, 9'h0FF, 9'h0FF, 9'h0FF}));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd1, 1, 0));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_ENCODE, 8'h01, 32'h0, 6'd0, 1, 0));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_END, 8'h00, 32'h0, 6'd0, 1, 2,
			{18'd0, 9'h107, 9'h001}));
		// zero length unloads an entry; unused command is dropped
		dir_rows.insert(dir_rows.size(), mk_row(CMD_LOAD, 8'h02, 32'hABCD_EF35, 6'd0, 1, 0));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_ENCODE, 8'h02, 32'h0, 6'd0, 1, 0));
		dir_rows.insert(dir_rows.size(), mk_row(2'd3, 8'h01, 32'hFFFF_FFFF, 6'd63, 1, 0));
		dir_rows.insert(dir_rows.size(),
			mk_row(CMD_END, 8'h00, 32'h0, 6'd0, 1, 1, {27'd0, 9'h100}));
		// code bits above the length are cleared; mixed alignments
		dir_rows.insert(dir_rows.size(), mk_row(CMD_LOAD, 8'h04, 32'hFFFF_FFF0, 6'd4));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_ENCODE, 8'h01, 32'h0, 6'd0));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_ENCODE, 8'h04, 32'h0, 6'd0));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_LOAD, 8'h03, 32'h0000_005A, 6'd7));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_ENCODE, 8'h03, 32'h0, 6'd0));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_ENCODE, 8'hFF, 32'h0, 6'd0));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_LOAD, 8'h07, 32'h8000_0001, 6'd32));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_ENCODE, 8'h01, 32'h0, 6'd0));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_ENCODE, 8'h01, 32'h0, 6'd0));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_ENCODE, 8'h07, 32'h0, 6'd0));
		dir_rows.insert(dir_rows.size(), mk_row(CMD_END, 8'h00, 32'h0, 6'd0));

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			issue(dir_rows[i]);
		live_syms = '{8'h00, 8'h01, 8'h03, 8'h04, 8'h07, 8'hFF};

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent == RANDOM_ITEMS / 2) begin
				// hold the sender until the output drains
				s_tvalid <= 1'b0;
				@(negedge clk);
				while (packed_bytes_q.size() != 0)
					@(negedge clk);
			end
			calm = (sent >= 300 && sent < 380);
			pick = $urandom_range(99);
			cmd = CMD_ENCODE;
			sym = 8'($urandom_range(255));
			len = '0;
			if (pick < 15) begin
				cmd = CMD_LOAD;
				if ($urandom_range(1) == 0)
					sym = 8'($urandom_range(31));
				pick = $urandom_range(99);
				if (pick < 8)
					len = 6'd0;
				else if (pick < 18)
					len = 6'($urandom_range(63, 33));
				else if (pick < 70)
					len = 6'($urandom_range(12, 1));
				else
					len = 6'($urandom_range(32, 1));
				r = mk_row(cmd, sym, $urandom, len);
				if (len != 6'd0)
					live_syms.insert(live_syms.size(), sym);
			end else if (pick < 87) begin
				if ($urandom_range(9) != 0)
					sym = live_syms[$urandom_range(live_syms.size() - 1)];
				r = mk_row(cmd, sym, $urandom, 6'($urandom));
			end else if (pick < 96) begin
				r = mk_row(CMD_END, sym, $urandom, 6'($urandom));
			end else begin
				r = mk_row(2'd3, sym, $urandom, 6'($urandom));
			end
			issue(r);
			if (r.cmd != 2'd3)
				sent++;
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (packed_bytes_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d loads, %0d encodes, %0d ends and %0d unused commands.",
			n_loads, n_encodes, n_ends, n_ignored);
		$display("Checked %0d packed bytes, %0d mismatches.", n_bytes, errors);
		if (errors == 0 && packed_bytes_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ huffman_encode_bit_packer_unit.f @@
hw/rtl/hebp_pkg.sv
hw/rtl/hebp_table.sv
hw/rtl/hebp_pack.sv
hw/rtl/hebp_emit.sv
hw/rtl/huffman_encode_bit_packer_unit.sv
bench/huffman_encode_bit_packer_unit_tb.sv
